FILE: rtl/core/bss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte sequence search package
// Shared sizes, configuration register indexes and transfer types.
// ----------------------------------------------------------------------------
package bss_pkg;

    // Longest pattern searched; one compare cell per pattern byte.
    localparam int PATTERN_MAX   = 16;
    // Position counter range is 2^POSITION_BITS bytes.
    localparam int POSITION_BITS = 16;
    localparam int COUNT_W       = POSITION_BITS + 1;

    // Fixed by the register map: two 64-bit pattern words, 5-bit length.
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 2;
    localparam int PAT_BYTES     = 16;
    localparam int PAT_IDX_W     = 4;
    localparam int LEN_W         = 5;
    localparam int MATCH_POS_W   = 16;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(1) << POSITION_BITS;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic                   found;
        logic [MATCH_POS_W-1:0] match_position;
        logic                   too_long;
    } out_item_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    // Byte i of the 16-byte pattern, byte 0 in bits 7:0 of the low word.
    function automatic logic [7:0] pattern_byte(
        input logic [CFG_DATA_W-1:0] pat_low,
        input logic [CFG_DATA_W-1:0] pat_high,
        input logic [PAT_IDX_W-1:0]  idx
    );
        logic [2*CFG_DATA_W-1:0] pat_all;
        pat_all = {pat_high, pat_low};
        return pat_all[8*idx +: 8];
    endfunction

endpackage

FILE: rtl/core/bss_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte sequence search compare cell
// Compares the byte arriving from its neighbor with one pattern byte and
// holds that byte for the next cell down the window.
// ----------------------------------------------------------------------------
module bss_cell (
    input  logic                aclk,
    input  bss_pkg::cell_ctrl_t ctrl,
    input  logic [7:0]          byte_in,
    input  logic [7:0]          ref_byte,
    input  logic                active,
    output logic [7:0]          byte_out,
    output logic                miss
);

    logic [7:0] byte_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            byte_reg <= 8'd0;
        end else if (ctrl.shift) begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;
    assign miss     = active && (byte_in != ref_byte);

endmodule

FILE: rtl/core/byte_sequence_search_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte sequence search unit
// Streams a buffer one byte per transfer and reports the first occurrence of
// a configured pattern of up to 16 bytes at the byte marked last.
// ----------------------------------------------------------------------------
// Takes one byte every clock cycle. A row of compare cells holds the most
// recent bytes and tests the full window against the pattern in the cycle the
// byte is taken, so the result for a buffer appears on m_valid in the cycle after
// the transfer of its last byte. The result sits in an output register; new
// bytes keep flowing while it waits unless that register is full and stalled.
// Write pattern_low, pattern_high and pattern_length through the cfg port
// between buffers. An empty pattern reports a match at offset 0. Buffers
// longer than 2^16 bytes set too_long; only matches ending in the first 2^16
// bytes are found.
// ----------------------------------------------------------------------------
module byte_sequence_search_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [bss_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [bss_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  bss_pkg::in_item_t                  s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output bss_pkg::out_item_t                 m_data
);

    logic [bss_pkg::CFG_DATA_W-1:0]    pat_low_reg;
    logic [bss_pkg::CFG_DATA_W-1:0]    pat_high_reg;
    logic [bss_pkg::LEN_W-1:0]         pat_len_reg;

    logic [bss_pkg::COUNT_W-1:0]       bytes_seen_reg, bytes_seen_next;
    logic                              match_seen_reg, match_seen_next;
    logic [bss_pkg::POSITION_BITS-1:0] first_match_reg, first_match_next;
    logic                              overflow_reg, overflow_next;
    logic                              m_valid_reg, m_valid_next;
    bss_pkg::out_item_t                m_data_reg, m_data_next;

    logic                              s_fire;
    bss_pkg::cell_ctrl_t               cell_ctrl;
    logic [7:0]                        link [bss_pkg::PATTERN_MAX];
    logic [bss_pkg::PATTERN_MAX-1:0]   cell_miss;
    logic                              saturated;
    logic [bss_pkg::COUNT_W-1:0]       count;
    logic [bss_pkg::COUNT_W-1:0]       len_ext;
    logic                              len_ok;
    logic                              hit;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                bss_pkg::CFG_PATTERN_LOW:    pat_low_reg  <= cfg_wdata;
                bss_pkg::CFG_PATTERN_HIGH:   pat_high_reg <= cfg_wdata;
                bss_pkg::CFG_PATTERN_LENGTH: pat_len_reg  <= cfg_wdata[bss_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_ready         = !m_valid_reg || m_ready;
    assign s_fire          = s_valid && s_ready;
    assign cell_ctrl.shift = s_fire;
    assign cell_ctrl.clear = s_fire && s_data.last_byte;

    // cell j compares the byte j places back from the newest with
    // pattern byte len-1-j
    assign link[0] = s_data.data_byte;

    for (genvar j = 0; j < bss_pkg::PATTERN_MAX; j++) begin : g_cell
        logic [bss_pkg::LEN_W-1:0] ref_idx;
        logic                      cell_active;

        assign ref_idx     = pat_len_reg - bss_pkg::LEN_W'(j + 1);
        assign cell_active = bss_pkg::LEN_W'(j) < pat_len_reg;

        if (j < bss_pkg::PATTERN_MAX - 1) begin : g_mid
            bss_cell u_cell (
                .aclk     (aclk),
                .ctrl     (cell_ctrl),
                .byte_in  (link[j]),
                .ref_byte (bss_pkg::pattern_byte(pat_low_reg, pat_high_reg,
                                                 ref_idx[bss_pkg::PAT_IDX_W-1:0])),
                .active   (cell_active),
                .byte_out (link[j+1]),
                .miss     (cell_miss[j])
            );
        end else begin : g_end
            bss_cell u_cell (
                .aclk     (aclk),
                .ctrl     (cell_ctrl),
                .byte_in  (link[j]),
                .ref_byte (bss_pkg::pattern_byte(pat_low_reg, pat_high_reg,
                                                 ref_idx[bss_pkg::PAT_IDX_W-1:0])),
                .active   (cell_active),
                .byte_out (),
                .miss     (cell_miss[j])
            );
        end
    end

    assign saturated = (bytes_seen_reg == bss_pkg::COUNT_LIMIT);
    assign count     = bytes_seen_reg + bss_pkg::COUNT_W'(1);
    assign len_ext   = bss_pkg::COUNT_W'(pat_len_reg);
    assign len_ok    = (pat_len_reg != '0)
                    && (pat_len_reg <= bss_pkg::LEN_W'(bss_pkg::PATTERN_MAX));
    assign hit       = !saturated && !match_seen_reg && len_ok && (count >= len_ext)
                    && (cell_miss == '0);

    always_comb begin
        bytes_seen_next  = bytes_seen_reg;
        match_seen_next  = match_seen_reg;
        first_match_next = first_match_reg;
        overflow_next    = overflow_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (s_fire) begin
            if (saturated) begin
                overflow_next = 1'b1;
            end else begin
                bytes_seen_next = count;
            end
            if (hit) begin
                match_seen_next  = 1'b1;
                first_match_next = bss_pkg::POSITION_BITS'(count - len_ext);
            end

            if (s_data.last_byte) begin
                m_valid_next              = 1'b1;
                m_data_next.too_long      = overflow_next;
                if (pat_len_reg == '0) begin
                    m_data_next.found          = 1'b1;
                    m_data_next.match_position = '0;
                end else if (match_seen_next) begin
                    m_data_next.found          = 1'b1;
                    m_data_next.match_position = bss_pkg::MATCH_POS_W'(first_match_next);
                end else begin
                    m_data_next.found          = 1'b0;
                    m_data_next.match_position = '0;
                end
                // ready for the next buffer
                bytes_seen_next  = '0;
                match_seen_next  = 1'b0;
                first_match_next = '0;
                overflow_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_seen_reg  <= '0;
            match_seen_reg  <= 1'b0;
            first_match_reg <= '0;
            overflow_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            bytes_seen_reg  <= bytes_seen_next;
            match_seen_reg  <= match_seen_next;
            first_match_reg <= first_match_next;
            overflow_reg    <= overflow_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: rtl/core/bss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte sequence search checker
// Port-level checks on the search unit, bound to the top level.
// ----------------------------------------------------------------------------
module bss_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input bss_pkg::in_item_t              s_data,
    input logic                           m_valid,
    input logic                           m_ready,
    input bss_pkg::out_item_t             m_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // input never blocked while the result register is free
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output register");

    // a last-byte transfer always yields a result next cycle
    a_last_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.last_byte |=> m_valid)
        else $error("missing result after last byte");

    // a new result only follows a last-byte transfer
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_data.last_byte))
        else $error("result without last byte");

    // no position reported without a match
    a_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.found |-> m_data.match_position == '0)
        else $error("position set without match");

endmodule

bind byte_sequence_search_unit bss_checker u_bss_checker (.*);
